// ===== src/igc_pkg.sv =====
package igc_pkg;

   localparam int FRAC_BITS_DEFAULT = 24;

   localparam int TEMP_W   = 32;
   localparam int HEAT_W   = 40;
   localparam int STATUS_W = 2;
   localparam int COEF_W   = 48;
   localparam int MASS_W   = 32;
   localparam int WORD_W   = 64;
   localparam int CSR_AW   = 6;
   localparam int CSR_DW   = 64;
   localparam int DV_W     = 42;
   localparam int Q2_W     = 40;

   localparam logic [22:0] GAS_CONST_E6 = 23'd8314462;
   localparam logic [9:0]  MILLI_DIV    = 10'd1000;
   localparam logic [MASS_W-1:0] MASS_RESET = 32'd65536;

   localparam logic [2:0] REG_COEF_A     = 3'd0;
   localparam logic [2:0] REG_COEF_B     = 3'd1;
   localparam logic [2:0] REG_COEF_C     = 3'd2;
   localparam logic [2:0] REG_COEF_D     = 3'd3;
   localparam logic [2:0] REG_COEF_E     = 3'd4;
   localparam logic [2:0] REG_COEF_F     = 3'd5;
   localparam logic [2:0] REG_COEF_G     = 3'd6;
   localparam logic [2:0] REG_MOLAR_MASS = 3'd7;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_CLAMP   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_SAT     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_DENZERO = 2'd3;

endpackage

// ===== src/igc_req_if.sv =====
interface igc_req_if;
   import igc_pkg::*;

   logic              valid;
   logic              ready;
   logic [TEMP_W-1:0] temperature;

   modport source (output valid, output temperature, input ready);
   modport sink   (input valid, input temperature, output ready);
endinterface

// ===== src/igc_rsp_if.sv =====
interface igc_rsp_if;
   import igc_pkg::*;

   logic                valid;
   logic                ready;
   logic [HEAT_W-1:0]   heat_capacity;
   logic [STATUS_W-1:0] status;

   modport source (output valid, output heat_capacity, output status, input ready);
   modport sink   (input valid, input heat_capacity, input status, output ready);
endinterface

// ===== src/ideal_gas_heat_capacity_eval_unit.sv =====
// Channel   Direction  Payload                          Handshake
// req_bus   in         temperature[31:0] Q16.16 K       valid/ready
// rsp_bus   out        heat_capacity[39:0], status[1:0] valid/ready
// csr (APB) in         64-bit registers at 8*index      psel/penable/pwrite
//
// One request per cycle while ready is high. The first divider chain has NW1 cells,
// NW1 = max(2*FRAC_BITS+16, 48)+1, and both divider chains resolve one quotient bit per cell.
// Reset is synchronous and clears every valid bit and restores the configuration registers.
// A stalled response parks in a one-entry skid; ready drops while the skid is
// full and the whole pipeline holds.
module ideal_gas_heat_capacity_eval_unit #(
   parameter int FRAC_BITS = igc_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   igc_req_if.sink                     req_bus,
   igc_rsp_if.source                   rsp_bus,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [igc_pkg::CSR_AW-1:0]  paddr,
   input  logic [igc_pkg::CSR_DW-1:0]  pwdata,
   output logic [igc_pkg::CSR_DW-1:0]  prdata,
   output logic                        pready
);
   import igc_pkg::*;

   localparam int NW1     = ((2 * FRAC_BITS + 16) > 48 ? (2 * FRAC_BITS + 16) : 48) + 1;
   localparam int DIV1_DW = 49;
   localparam int NW2     = 119 - FRAC_BITS;
   localparam int NST     = 18;
   localparam logic [63:0] ONE = 64'd1 << FRAC_BITS;

   typedef struct packed {
      logic [63:0]         y;
      logic [63:0]         om;
      logic [63:0]         y2;
      logic [63:0]         cb;
      logic [63:0]         p;
      logic [63:0]         cy;
      logic [63:0]         inner;
      logic [63:0]         s;
      logic                ovf;
      logic                dz;
      logic [STATUS_W-1:0] status;
      logic                sat;
      logic                use_q;
   } ctx_type;

   function automatic logic [64:0] sadd(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] t;
      t = {a[63], a} + {b[63], b};
      return {t[64] ^ t[63], t[63:0]};
   endfunction

   function automatic logic [64:0] ssub(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] t;
      t = {a[63], a} - {b[63], b};
      return {t[64] ^ t[63], t[63:0]};
   endfunction

   function automatic logic [63:0] sx(input logic [COEF_W-1:0] c);
      return {{(64 - COEF_W){c[COEF_W-1]}}, c};
   endfunction

   // configuration registers
   logic [COEF_W-1:0] coef_a_ff, coef_b_ff, coef_c_ff, coef_d_ff;
   logic [COEF_W-1:0] coef_e_ff, coef_f_ff, coef_g_ff;
   logic [MASS_W-1:0] molar_mass_ff;
   logic [DV_W-1:0]   dv_ff;
   logic              csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_a_ff     <= '0;
         coef_b_ff     <= '0;
         coef_c_ff     <= '0;
         coef_d_ff     <= '0;
         coef_e_ff     <= '0;
         coef_f_ff     <= '0;
         coef_g_ff     <= '0;
         molar_mass_ff <= MASS_RESET;
      end else if (csr_wr) begin
         unique case (paddr[5:3])
            REG_COEF_A:     coef_a_ff     <= pwdata[COEF_W-1:0];
            REG_COEF_B:     coef_b_ff     <= pwdata[COEF_W-1:0];
            REG_COEF_C:     coef_c_ff     <= pwdata[COEF_W-1:0];
            REG_COEF_D:     coef_d_ff     <= pwdata[COEF_W-1:0];
            REG_COEF_E:     coef_e_ff     <= pwdata[COEF_W-1:0];
            REG_COEF_F:     coef_f_ff     <= pwdata[COEF_W-1:0];
            REG_COEF_G:     coef_g_ff     <= pwdata[COEF_W-1:0];
            REG_MOLAR_MASS: molar_mass_ff <= pwdata[MASS_W-1:0];
            default:        coef_a_ff     <= coef_a_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[5:3])
         REG_COEF_A:     prdata = sx(coef_a_ff);
         REG_COEF_B:     prdata = sx(coef_b_ff);
         REG_COEF_C:     prdata = sx(coef_c_ff);
         REG_COEF_D:     prdata = sx(coef_d_ff);
         REG_COEF_E:     prdata = sx(coef_e_ff);
         REG_COEF_F:     prdata = sx(coef_f_ff);
         REG_COEF_G:     prdata = sx(coef_g_ff);
         REG_MOLAR_MASS: prdata = {32'd0, molar_mass_ff};
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      dv_ff <= DV_W'(molar_mass_ff) * DV_W'(MILLI_DIV);
   end

   // flow control
   logic pipe_en, skid_v_ff, out_v_ff;
   assign pipe_en       = ~skid_v_ff;
   assign req_bus.ready = pipe_en;

   // front end: scale T, form A+T, its magnitude, then the numerator
   logic [63:0]        tq_in;
   logic               pre0_v_ff, pre1_v_ff, pre2_v_ff;
   logic [63:0]        tq0_ff, den_ff, tq1_ff;
   logic [DIV1_DW-1:0] ad1_ff, ad2_ff;
   logic               neg1_ff, dz1_ff, neg2_ff, dz2_ff;
   logic [NW1-1:0]     num_ff;
   logic [127:0]       num_wide;

   if (FRAC_BITS >= 16) begin : g_tq_up
      assign tq_in = {32'd0, req_bus.temperature} << (FRAC_BITS - 16);
   end else begin : g_tq_dn
      assign tq_in = {32'd0, req_bus.temperature} >> (16 - FRAC_BITS);
   end

   assign num_wide = (128'(tq1_ff) << FRAC_BITS) + 128'(ad1_ff >> 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         pre0_v_ff <= 1'b0;
         pre1_v_ff <= 1'b0;
         pre2_v_ff <= 1'b0;
      end else if (pipe_en) begin
         pre0_v_ff <= req_bus.valid;
         pre1_v_ff <= pre0_v_ff;
         pre2_v_ff <= pre1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         tq0_ff  <= tq_in;
         den_ff  <= sx(coef_a_ff) + tq_in;
         tq1_ff  <= tq0_ff;
         ad1_ff  <= den_ff[63] ? DIV1_DW'(~den_ff + 64'd1) : den_ff[DIV1_DW-1:0];
         neg1_ff <= den_ff[63];
         dz1_ff  <= (den_ff == 64'd0);
         num_ff  <= num_wide[NW1-1:0];
         ad2_ff  <= ad1_ff;
         neg2_ff <= neg1_ff;
         dz2_ff  <= dz1_ff;
      end
   end

   // y = T / (A + T): one quotient bit per cell
   logic [NW1:0]       d1_v;
   logic [DIV1_DW-1:0] d1_rem [NW1+1];
   logic [NW1-1:0]     d1_nq  [NW1+1];
   logic [DIV1_DW-1:0] d1_div [NW1+1];
   logic [1:0]         d1_side[NW1+1];

   assign d1_v[0]    = pre2_v_ff;
   assign d1_rem[0]  = '0;
   assign d1_nq[0]   = num_ff;
   assign d1_div[0]  = ad2_ff;
   assign d1_side[0] = {dz2_ff, neg2_ff};

   for (genvar i = 0; i < NW1; i++) begin : g_div1
      igc_div_cell #(.DW(DIV1_DW), .QW(NW1), .SW(2)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .enable   (pipe_en),
         .in_valid (d1_v[i]),
         .in_rem   (d1_rem[i]),
         .in_nq    (d1_nq[i]),
         .in_div   (d1_div[i]),
         .in_side  (d1_side[i]),
         .out_valid(d1_v[i+1]),
         .out_rem  (d1_rem[i+1]),
         .out_nq   (d1_nq[i+1]),
         .out_div  (d1_div[i+1]),
         .out_side (d1_side[i+1])
      );
   end

   // polynomial pipeline
   ctx_type        ctx_ff [NST];
   ctx_type        ctx_in [NST];
   logic [NST-1:0] cv_ff;

   logic [63:0] ma_p, my_p, mb_p, mc_p, md_p, me_p, mf_p;
   logic        ma_o, my_o, mb_o, mc_o, md_o, me_o, mf_o;

   igc_qmul #(.FRAC_BITS(FRAC_BITS)) u_mul_a (
      .clock(clock), .enable(pipe_en), .a_val(ctx_ff[0].y), .b_val(sx(coef_g_ff)),
      .prod(ma_p), .prod_ovf(ma_o));
   igc_qmul #(.FRAC_BITS(FRAC_BITS)) u_mul_y (
      .clock(clock), .enable(pipe_en), .a_val(ctx_ff[0].y), .b_val(ctx_ff[0].y),
      .prod(my_p), .prod_ovf(my_o));
   igc_qmul #(.FRAC_BITS(FRAC_BITS)) u_mul_b (
      .clock(clock), .enable(pipe_en), .a_val(ctx_ff[3].y), .b_val(ctx_ff[3].p),
      .prod(mb_p), .prod_ovf(mb_o));
   igc_qmul #(.FRAC_BITS(FRAC_BITS)) u_mul_c (
      .clock(clock), .enable(pipe_en), .a_val(ctx_ff[6].y), .b_val(ctx_ff[6].p),
      .prod(mc_p), .prod_ovf(mc_o));
   igc_qmul #(.FRAC_BITS(FRAC_BITS)) u_mul_d (
      .clock(clock), .enable(pipe_en), .a_val(ctx_ff[9].om), .b_val(ctx_ff[9].p),
      .prod(md_p), .prod_ovf(md_o));
   igc_qmul #(.FRAC_BITS(FRAC_BITS)) u_mul_e (
      .clock(clock), .enable(pipe_en), .a_val(ctx_ff[9].cb), .b_val(ctx_ff[9].y2),
      .prod(me_p), .prod_ovf(me_o));
   igc_qmul #(.FRAC_BITS(FRAC_BITS)) u_mul_f (
      .clock(clock), .enable(pipe_en), .a_val(ctx_ff[12].cy), .b_val(ctx_ff[12].inner),
      .prod(mf_p), .prod_ovf(mf_o));

   logic [127:0] q1_wide;
   logic         q1_neg;
   logic [64:0]  r_om, r_cb, r_p3, r_p6, r_p9, r_in, r_s;
   logic [63:0]  s15;
   logic         s15_pos;

   always_comb begin
      q1_wide = 128'(d1_nq[NW1]);
      q1_neg  = d1_side[NW1][0];
      r_om    = ssub(ONE, ctx_ff[0].y);
      r_cb    = ssub(sx(coef_c_ff), sx(coef_b_ff));
      r_p3    = sadd(sx(coef_f_ff), ma_p);
      r_p6    = sadd(sx(coef_e_ff), mb_p);
      r_p9    = sadd(sx(coef_d_ff), mc_p);
      r_in    = ssub(ONE, md_p);
      r_s     = sadd(sx(coef_b_ff), mf_p);
      s15     = ctx_ff[15].s;
      s15_pos = ~s15[63] && (s15 != 64'd0);

      ctx_in[0]     = '0;
      ctx_in[0].y   = q1_neg ? (~q1_wide[63:0] + 64'd1) : q1_wide[63:0];
      ctx_in[0].ovf = q1_wide > (q1_neg ? 128'h8000_0000_0000_0000
                                        : 128'h7FFF_FFFF_FFFF_FFFF);
      ctx_in[0].dz  = d1_side[NW1][1];

      for (int k = 1; k < NST; k++) begin
         ctx_in[k] = ctx_ff[k-1];
      end

      ctx_in[1].om  = r_om[63:0];
      ctx_in[1].cb  = r_cb[63:0];
      ctx_in[1].ovf = ctx_ff[0].ovf | r_om[64] | r_cb[64];

      ctx_in[3].p   = r_p3[63:0];
      ctx_in[3].y2  = my_p;
      ctx_in[3].ovf = ctx_ff[2].ovf | ma_o | my_o | r_p3[64];

      ctx_in[6].p   = r_p6[63:0];
      ctx_in[6].ovf = ctx_ff[5].ovf | mb_o | r_p6[64];

      ctx_in[9].p   = r_p9[63:0];
      ctx_in[9].ovf = ctx_ff[8].ovf | mc_o | r_p9[64];

      ctx_in[12].inner = r_in[63:0];
      ctx_in[12].cy    = me_p;
      ctx_in[12].ovf   = ctx_ff[11].ovf | md_o | me_o | r_in[64];

      ctx_in[15].s   = r_s[63:0];
      ctx_in[15].ovf = ctx_ff[14].ovf | mf_o | r_s[64];

      ctx_in[16].sat   = 1'b0;
      ctx_in[16].use_q = 1'b0;
      priority if (ctx_ff[15].dz) begin
         ctx_in[16].status = ST_DENZERO;
      end else if (ctx_ff[15].ovf || (s15_pos && molar_mass_ff == '0)) begin
         ctx_in[16].status = ST_SAT;
         ctx_in[16].sat    = 1'b1;
      end else if (s15[63]) begin
         ctx_in[16].status = ST_CLAMP;
      end else if (!s15_pos) begin
         ctx_in[16].status = ST_OK;
      end else begin
         ctx_in[16].status = ST_OK;
         ctx_in[16].use_q  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff <= '0;
      end else if (pipe_en) begin
         cv_ff <= {cv_ff[NST-2:0], d1_v[NW1]};
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         for (int k = 0; k < NST; k++) begin
            ctx_ff[k] <= ctx_in[k];
         end
      end
   end

   // scale by R / (1000 M)
   logic [54:0]    pp_lo_ff;
   logic [53:0]    pp_hi_ff;
   logic [NW2-1:0] n_ff;
   logic [127:0]   n_wide;

   assign n_wide = (((128'(pp_hi_ff) << 32) + 128'(pp_lo_ff)) << (32 - FRAC_BITS))
                 + 128'(dv_ff >> 1);

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         pp_lo_ff <= {23'd0, s15[31:0]} * {32'd0, GAS_CONST_E6};
         pp_hi_ff <= {23'd0, s15[62:32]} * {31'd0, GAS_CONST_E6};
         n_ff     <= n_wide[NW2-1:0];
      end
   end

   logic                big2;
   logic [STATUS_W-1:0] st2;

   assign big2 = ctx_ff[17].use_q && (n_ff >= (NW2'(dv_ff) << Q2_W));
   assign st2  = big2 ? ST_SAT : ctx_ff[17].status;

   logic [Q2_W:0]     d2_v;
   logic [DV_W-1:0]   d2_rem [Q2_W+1];
   logic [Q2_W-1:0]   d2_nq  [Q2_W+1];
   logic [DV_W-1:0]   d2_div [Q2_W+1];
   logic [3:0]        d2_side[Q2_W+1];

   assign d2_v[0]    = cv_ff[NST-1];
   assign d2_rem[0]  = n_ff[DV_W+Q2_W-1:Q2_W];
   assign d2_nq[0]   = n_ff[Q2_W-1:0];
   assign d2_div[0]  = dv_ff;
   assign d2_side[0] = {st2, ctx_ff[17].sat | big2, ctx_ff[17].use_q & ~big2};

   for (genvar i = 0; i < Q2_W; i++) begin : g_div2
      igc_div_cell #(.DW(DV_W), .QW(Q2_W), .SW(4)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .enable   (pipe_en),
         .in_valid (d2_v[i]),
         .in_rem   (d2_rem[i]),
         .in_nq    (d2_nq[i]),
         .in_div   (d2_div[i]),
         .in_side  (d2_side[i]),
         .out_valid(d2_v[i+1]),
         .out_rem  (d2_rem[i+1]),
         .out_nq   (d2_nq[i+1]),
         .out_div  (d2_div[i+1]),
         .out_side (d2_side[i+1])
      );
   end

   // result and skid
   logic                push;
   logic [HEAT_W-1:0]   pd_heat;
   logic [STATUS_W-1:0] pd_status;
   logic [HEAT_W-1:0]   out_heat_ff, skid_heat_ff;
   logic [STATUS_W-1:0] out_status_ff, skid_status_ff;

   assign push      = pipe_en && d2_v[Q2_W];
   assign pd_status = d2_side[Q2_W][3:2];
   assign pd_heat   = d2_side[Q2_W][1] ? {HEAT_W{1'b1}}
                    : d2_side[Q2_W][0] ? d2_nq[Q2_W] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (out_v_ff && !rsp_bus.ready) begin
         if (push) begin
            skid_v_ff      <= 1'b1;
            skid_heat_ff   <= pd_heat;
            skid_status_ff <= pd_status;
         end
      end else if (skid_v_ff) begin
         out_v_ff      <= 1'b1;
         skid_v_ff     <= 1'b0;
         out_heat_ff   <= skid_heat_ff;
         out_status_ff <= skid_status_ff;
      end else begin
         out_v_ff      <= push;
         out_heat_ff   <= pd_heat;
         out_status_ff <= pd_status;
      end
   end

   assign rsp_bus.valid         = out_v_ff;
   assign rsp_bus.heat_capacity = out_heat_ff;
   assign rsp_bus.status        = out_status_ff;
endmodule

// ===== src/igc_div_cell.sv =====
module igc_div_cell #(
   parameter int DW = 49,
   parameter int QW = 65,
   parameter int SW = 2
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          enable,
   input  logic          in_valid,
   input  logic [DW-1:0] in_rem,
   input  logic [QW-1:0] in_nq,
   input  logic [DW-1:0] in_div,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [DW-1:0] out_rem,
   output logic [QW-1:0] out_nq,
   output logic [DW-1:0] out_div,
   output logic [SW-1:0] out_side
);
   logic [DW:0]   shifted;
   logic [DW+1:0] diff;
   logic          take;
   logic          valid_ff;
   logic [DW-1:0] rem_ff, div_ff, rem_in;
   logic [QW-1:0] nq_ff;
   logic [SW-1:0] side_ff;

   // one restoring step: shift in the next numerator bit, subtract if it fits
   always_comb begin
      shifted = {in_rem, in_nq[QW-1]};
      diff    = {1'b0, shifted} - {2'b00, in_div};
      take    = ~diff[DW+1];
      rem_in  = take ? diff[DW-1:0] : shifted[DW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff  <= rem_in;
         nq_ff   <= {in_nq[QW-2:0], take};
         div_ff  <= in_div;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_nq    = nq_ff;
   assign out_div   = div_ff;
   assign out_side  = side_ff;
endmodule

// ===== src/igc_qmul.sv =====
module igc_qmul #(
   parameter int FRAC_BITS = igc_pkg::FRAC_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        enable,
   input  logic [63:0] a_val,
   input  logic [63:0] b_val,
   output logic [63:0] prod,
   output logic        prod_ovf
);
   import igc_pkg::*;

   logic [WORD_W-1:0] ma, mb;
   logic [WORD_W-1:0] pp00_ff, pp01_ff, pp10_ff, pp11_ff;
   logic              neg_ff;
   logic [127:0]      full, rnd, mval;
   logic [WORD_W-1:0] lim, res;
   logic              ovf;
   logic [WORD_W-1:0] prod_ff;
   logic              ovf_ff;

   assign ma = a_val[63] ? (~a_val + 64'd1) : a_val;
   assign mb = b_val[63] ? (~b_val + 64'd1) : b_val;

   always_ff @(posedge clock) begin
      if (enable) begin
         pp00_ff <= {32'd0, ma[31:0]}  * {32'd0, mb[31:0]};
         pp01_ff <= {32'd0, ma[31:0]}  * {32'd0, mb[63:32]};
         pp10_ff <= {32'd0, ma[63:32]} * {32'd0, mb[31:0]};
         pp11_ff <= {32'd0, ma[63:32]} * {32'd0, mb[63:32]};
         neg_ff  <= a_val[63] ^ b_val[63];
      end
   end

   // round half away from zero on the magnitude, then range check
   always_comb begin
      full = {64'd0, pp00_ff} + {32'd0, pp01_ff, 32'd0} + {32'd0, pp10_ff, 32'd0}
           + {pp11_ff, 64'd0};
      rnd  = full + (128'd1 << (FRAC_BITS - 1));
      mval = rnd >> FRAC_BITS;
      lim  = neg_ff ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      ovf  = (mval[127:64] != 64'd0) || (mval[63:0] > lim);
      res  = neg_ff ? (~mval[63:0] + 64'd1) : mval[63:0];
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff <= res;
         ovf_ff  <= ovf;
      end
   end

   assign prod     = prod_ff;
   assign prod_ovf = ovf_ff;
endmodule
